// ===== rtl/sfz_pkg.sv =====
// shared types and constants of the symmetric fir filter core
`default_nettype none

package sfz_pkg;

   localparam int COEF_WIDTH      = 18;
   localparam int FRAC_BITS       = 16;
   localparam int TAPS_WIDTH      = 3;
   localparam int POS_WIDTH       = 3;
   localparam int SEEN_WIDTH      = 4;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [SEEN_WIDTH-1:0]      SEEN_MAX         = 4'd15;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NUM_COEFFS   = 3'd0;
   localparam logic [TAPS_WIDTH-1:0]      NUM_COEFFS_RESET = 3'd1;
   localparam logic [COEF_WIDTH-1:0]      COEF0_RESET      = 18'd65536;

   typedef struct packed {
      logic                  flush;
      logic                  emit;
      logic [TAPS_WIDTH-1:0] taps;
      logic [POS_WIDTH-1:0]  pos;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOAD,
      BK_ALIGN,
      BK_MAC,
      BK_DRAIN,
      BK_OUT
   } bk_state_type;

endpackage

`default_nettype wire

// ===== rtl/sfz_front.sv =====
// front end: accepts sample beats, counts the array and classifies each beat
`default_nettype none

module sfz_front import sfz_pkg::*; #(
   parameter int MAX_COEFFS   = 7,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [SAMPLE_WIDTH-1:0] req_sample_in,
   input  wire logic                    req_end_of_array,
   input  wire logic [TAPS_WIDTH-1:0]   num_coeffs,
   output logic                         push_valid,
   input  wire logic                    push_ready,
   output logic [SAMPLE_WIDTH-1:0]      push_sample,
   output cmd_type                      push_cmd
);

   localparam logic [TAPS_WIDTH-1:0] MAX_TAPS = TAPS_WIDTH'(MAX_COEFFS);

   logic [SEEN_WIDTH-1:0] seen_ff;
   logic [SEEN_WIDTH-1:0] seen_in;
   logic [SEEN_WIDTH-1:0] seen_inc;
   logic [SEEN_WIDTH-1:0] half_plus;
   logic [SEEN_WIDTH-1:0] flush_count;
   logic [TAPS_WIDTH-1:0] taps;
   logic [TAPS_WIDTH-1:0] half;
   logic                  accept;

   assign accept     = req_valid && push_ready;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign push_sample = req_sample_in;

   always_comb begin
      seen_inc    = (seen_ff == SEEN_MAX) ? SEEN_MAX : seen_ff + 1'b1;
      taps        = (num_coeffs > MAX_TAPS) ? MAX_TAPS : num_coeffs;
      half        = (taps == '0) ? '0 : taps - 1'b1;
      half_plus   = {1'b0, half} + 1'b1;
      flush_count = (seen_inc < half_plus) ? seen_inc : half_plus;

      push_cmd.taps  = taps;
      push_cmd.flush = req_end_of_array;
      if (req_end_of_array) begin
         push_cmd.emit = 1'b1;
         push_cmd.pos  = POS_WIDTH'(flush_count - 1'b1);
      end else begin
         push_cmd.emit = seen_inc > {1'b0, half};
         push_cmd.pos  = POS_WIDTH'(half);
      end
   end

   always_comb begin
      seen_in = seen_ff;
      if (accept) begin
         seen_in = req_end_of_array ? '0 : seen_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sfz_cmd_fifo.sv =====
// short queue of classified beats between front and back end
`default_nettype none

module sfz_cmd_fifo import sfz_pkg::*; #(
   parameter int WIDTH = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      out_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign in_ready  = count_ff != CNT_FULL;
   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sfz_back.sv =====
// back end: sample window, tap lines, multiply-accumulate and output register
`default_nettype none

module sfz_back import sfz_pkg::*; #(
   parameter int MAX_COEFFS   = 7,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  q_valid,
   output logic                                       q_ready,
   input  wire logic [SAMPLE_WIDTH-1:0]               q_sample,
   input  wire cmd_type                               q_cmd,
   input  wire logic [MAX_COEFFS-1:0][COEF_WIDTH-1:0] coefs,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [SAMPLE_WIDTH-1:0]                    rsp_sample_out,
   output logic                                       rsp_last_out
);

   localparam int SW     = SAMPLE_WIDTH;
   localparam int CTR    = MAX_COEFFS - 1;
   localparam int WIN    = 2 * MAX_COEFFS - 1;
   localparam int LINE   = MAX_COEFFS;
   localparam int IDX_W  = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
   localparam int OPW    = SW + 1;
   localparam int PRODW  = COEF_WIDTH + OPW;
   localparam int ACCW   = PRODW + 3;
   localparam int RW     = ACCW - FRAC_BITS;
   localparam logic [POS_WIDTH-1:0] CTR_POS = POS_WIDTH'(CTR);
   localparam logic signed [ACCW-1:0] RND_HALF =
      {{(ACCW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
   localparam logic signed [RW-1:0] SAT_HI = {{(RW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
   localparam logic signed [RW-1:0] SAT_LO = {{(RW - SW + 1){1'b1}}, {(SW - 1){1'b0}}};

   bk_state_type state_ff;
   bk_state_type state_in;

   logic signed [SW-1:0]    win_ff [WIN];
   logic signed [SW-1:0]    win_in [WIN];
   logic signed [SW-1:0]    lft_ff [LINE];
   logic signed [SW-1:0]    lft_in [LINE];
   logic signed [SW-1:0]    rgt_ff [LINE];
   logic signed [SW-1:0]    rgt_in [LINE];
   logic [SW-1:0]           hold_ff;
   logic [SW-1:0]           hold_in;
   logic                    flush_ff;
   logic                    flush_in;
   logic [TAPS_WIDTH-1:0]   taps_ff;
   logic [TAPS_WIDTH-1:0]   taps_in;
   logic [POS_WIDTH-1:0]    pos_ff;
   logic [POS_WIDTH-1:0]    pos_in;
   logic [POS_WIDTH-1:0]    align_ff;
   logic [POS_WIDTH-1:0]    align_in;
   logic [IDX_W-1:0]        tap_ff;
   logic [IDX_W-1:0]        tap_in;
   logic signed [PRODW-1:0] prod_ff;
   logic signed [PRODW-1:0] prod_in;
   logic                    prod_vld_ff;
   logic                    prod_vld_in;
   logic signed [ACCW-1:0]  acc_ff;
   logic signed [ACCW-1:0]  acc_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [SW-1:0]           rsp_sample_ff;
   logic [SW-1:0]           rsp_sample_in;
   logic                    rsp_last_ff;
   logic                    rsp_last_in;

   logic                    out_free;
   logic                    last_tap;
   logic signed [OPW-1:0]   mul_op;
   logic signed [COEF_WIDTH-1:0] coef_sel;
   logic signed [ACCW-1:0]  prod_ext;
   logic signed [ACCW-1:0]  rnd_sum;
   logic signed [RW-1:0]    rnd_q;
   logic [SW-1:0]           sat_val;

   assign q_ready        = state_ff == BK_IDLE;
   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign last_tap       = TAPS_WIDTH'(tap_ff) == taps_ff - 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_last_out   = rsp_last_ff;

   assign coef_sel = $signed(coefs[tap_ff]);
   assign mul_op   = (tap_ff == '0) ? {lft_ff[0][SW-1], lft_ff[0]} :
                     {lft_ff[0][SW-1], lft_ff[0]} + {rgt_ff[0][SW-1], rgt_ff[0]};
   assign prod_ext = {{(ACCW - PRODW){prod_ff[PRODW-1]}}, prod_ff};
   assign rnd_sum  = acc_ff + RND_HALF;
   assign rnd_q    = rnd_sum[ACCW-1:FRAC_BITS];

   always_comb begin
      if (rnd_q > SAT_HI) begin
         sat_val = SAT_HI[SW-1:0];
      end else if (rnd_q < SAT_LO) begin
         sat_val = SAT_LO[SW-1:0];
      end else begin
         sat_val = rnd_q[SW-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && q_cmd.emit) begin
               state_in = (q_cmd.taps == '0) ? BK_OUT : BK_LOAD;
            end
         end
         BK_LOAD:  state_in = BK_ALIGN;
         BK_ALIGN: begin
            if (align_ff == '0) begin
               state_in = BK_MAC;
            end
         end
         BK_MAC: begin
            if (last_tap) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: state_in = BK_OUT;
         BK_OUT: begin
            if (out_free) begin
               state_in = (flush_ff && pos_ff != '0) ? BK_LOAD : BK_IDLE;
            end
         end
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      win_in        = win_ff;
      lft_in        = lft_ff;
      rgt_in        = rgt_ff;
      hold_in       = hold_ff;
      flush_in      = flush_ff;
      taps_in       = taps_ff;
      pos_in        = pos_ff;
      align_in      = align_ff;
      tap_in        = tap_ff;
      prod_in       = prod_ff;
      prod_vld_in   = prod_vld_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               win_in[0] = $signed(q_sample);
               for (int k = 1; k < WIN; k++) begin
                  win_in[k] = win_ff[k-1];
               end
               hold_in  = q_sample;
               flush_in = q_cmd.flush;
               taps_in  = q_cmd.taps;
               pos_in   = q_cmd.pos;
            end
         end
         BK_LOAD: begin
            for (int k = 0; k < LINE; k++) begin
               lft_in[k] = win_ff[CTR+k];
               rgt_in[k] = win_ff[CTR-k];
            end
            align_in    = CTR_POS - pos_ff;
            tap_in      = '0;
            acc_in      = '0;
            prod_vld_in = 1'b0;
         end
         BK_ALIGN: begin
            // move the centre one sample toward the newest end
            if (align_ff != '0) begin
               for (int k = 0; k < LINE; k++) begin
                  if (k < CTR) begin
                     rgt_in[k] = rgt_ff[k+1];
                  end else begin
                     rgt_in[k] = '0;
                  end
                  if (k > 0) begin
                     lft_in[k] = lft_ff[k-1];
                  end
               end
               lft_in[0] = rgt_in[0];
               align_in  = align_ff - 1'b1;
            end
         end
         BK_MAC: begin
            prod_in     = coef_sel * mul_op;
            prod_vld_in = 1'b1;
            if (prod_vld_ff) begin
               acc_in = acc_ff + prod_ext;
            end
            for (int k = 0; k < LINE; k++) begin
               if (k < CTR) begin
                  lft_in[k] = lft_ff[k+1];
                  rgt_in[k] = rgt_ff[k+1];
               end else begin
                  lft_in[k] = '0;
                  rgt_in[k] = '0;
               end
            end
            tap_in = tap_ff + 1'b1;
         end
         BK_DRAIN: begin
            acc_in = acc_ff + prod_ext;
         end
         BK_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = (taps_ff == '0) ? hold_ff : sat_val;
               rsp_last_in   = flush_ff && pos_ff == '0;
               if (flush_ff && pos_ff != '0) begin
                  pos_in = pos_ff - 1'b1;
               end else if (flush_ff) begin
                  for (int k = 0; k < WIN; k++) begin
                     win_in[k] = '0;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < WIN; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
      lft_ff        <= lft_in;
      rgt_ff        <= rgt_in;
      hold_ff       <= hold_in;
      flush_ff      <= flush_in;
      taps_ff       <= taps_in;
      pos_ff        <= pos_in;
      align_ff      <= align_in;
      tap_ff        <= tap_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

`default_nettype wire

// ===== rtl/symmetric_fir_zero_edge_filter_core.sv =====
// top level: control registers, front end, command queue and back end
// a beat with a result passes the queue and back end states LOAD, ALIGN, MAC, DRAIN and OUT,
// ALIGN moves the centre to position p and MAC runs n taps; with no taps IDLE goes to OUT
// the back end takes a beat with no result in IDLE, else it takes no beat until back in IDLE
// a last beat gives min(seen, n) results (one with no taps), each through LOAD to OUT in turn
// synchronous reset clears the window, counters, queue and output, and loads register defaults
`default_nettype none

module symmetric_fir_zero_edge_filter_core import sfz_pkg::*; #(
   parameter int MAX_COEFFS   = 7,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [SAMPLE_WIDTH-1:0]    req_sample_in,
   input  wire logic                       req_end_of_array,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [SAMPLE_WIDTH-1:0]         rsp_sample_out,
   output logic                            rsp_last_out,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [COEF_WIDTH-1:0]      csr_wdata
);

   localparam int QW = SAMPLE_WIDTH + $bits(cmd_type);

   logic [TAPS_WIDTH-1:0]                 num_coeffs_ff;
   logic [TAPS_WIDTH-1:0]                 num_coeffs_in;
   logic [MAX_COEFFS-1:0][COEF_WIDTH-1:0] coef_ff;
   logic [MAX_COEFFS-1:0][COEF_WIDTH-1:0] coef_in;

   logic                    push_valid;
   logic                    push_ready;
   logic [SAMPLE_WIDTH-1:0] push_sample;
   cmd_type                 push_cmd;
   logic                    q_valid;
   logic                    q_ready;
   logic [QW-1:0]           q_data;
   cmd_type                 q_cmd;

   assign q_cmd = q_data[$bits(cmd_type)-1:0];

   always_comb begin
      num_coeffs_in = num_coeffs_ff;
      coef_in       = coef_ff;
      if (csr_we && csr_index == REG_NUM_COEFFS) begin
         num_coeffs_in = csr_wdata[TAPS_WIDTH-1:0];
      end
      for (int k = 0; k < MAX_COEFFS; k++) begin
         if (csr_we && csr_index == CSR_INDEX_WIDTH'(k + 1)) begin
            coef_in[k] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_coeffs_ff <= NUM_COEFFS_RESET;
         for (int k = 0; k < MAX_COEFFS; k++) begin
            coef_ff[k] <= (k == 0) ? COEF0_RESET : '0;
         end
      end else begin
         num_coeffs_ff <= num_coeffs_in;
         coef_ff       <= coef_in;
      end
   end

   sfz_front #(
      .MAX_COEFFS   (MAX_COEFFS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_in    (req_sample_in),
      .req_end_of_array (req_end_of_array),
      .num_coeffs       (num_coeffs_ff),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_sample      (push_sample),
      .push_cmd         (push_cmd)
   );

   sfz_cmd_fifo #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   ({push_sample, push_cmd}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   sfz_back #(
      .MAX_COEFFS   (MAX_COEFFS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_sample       (q_data[QW-1:$bits(cmd_type)]),
      .q_cmd          (q_cmd),
      .coefs          (coef_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_last_out   (rsp_last_out)
   );

endmodule

`default_nettype wire

// ===== verif/tb_symmetric_fir_zero_edge_filter_core.sv =====
// self-checking testbench for the symmetric fir filter core with zero edges
`default_nettype none

module tb_symmetric_fir_zero_edge_filter_core import sfz_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W     = 16;
   localparam int MAX_TAPS     = 7;
   localparam int WIN_LEN      = 2 * MAX_TAPS - 1;
   localparam int RANDOM_BEATS = 300;
   localparam int DRAIN_CYCLES = 120;
   localparam int HOLD_AT      = 80;
   localparam int HOLD_CYCLES  = 400;
   localparam int STEADY_FROM  = 180;
   localparam int STEADY_TO    = 240;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_0 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_1 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_2 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_3 = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_4 = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_5 = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_6 = 3'd7;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last_flag;
   } filt_result_type;

   typedef enum logic [1:0] {
      ROW_BEAT,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [COEF_WIDTH-1:0]      data;
      logic [SAMPLE_W-1:0]        sample;
      logic                       eoa;
      logic                       typed;
      logic [SAMPLE_W-1:0]        exp_sample;
      logic                       exp_last;
   } stim_row_type;

   // kind, register, write data, sample, end of array, typed, expected sample, expected last
   localparam stim_row_type DIRECTED [37] = '{
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h7FFF, 1'b1, 1'b1, 16'h7FFF, 1'b1},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h8000, 1'b1, 1'b1, 16'h8000, 1'b1},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h1234, 1'b0, 1'b1, 16'h1234, 1'b0},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1},
      '{ROW_CSR,  REG_NUM_COEFFS, 18'd0,     16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h5555, 1'b0, 1'b1, 16'h5555, 1'b0},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'hAAAA, 1'b1, 1'b1, 16'hAAAA, 1'b1},
      '{ROW_CSR,  REG_NUM_COEFFS, 18'd1,     16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  REG_COEF_0,     18'h20000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h7FFF, 1'b1, 1'b1, 16'h8000, 1'b1},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h8000, 1'b1, 1'b1, 16'h7FFF, 1'b1},
      '{ROW_CSR,  REG_NUM_COEFFS, 18'd7,     16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  REG_COEF_0,     18'h1FFFF, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  REG_COEF_1,     18'h20000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  REG_COEF_2,     18'h08000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  REG_COEF_3,     18'h3C000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  REG_COEF_4,     18'h01000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  REG_COEF_5,     18'h3FFFF, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  REG_COEF_6,     18'h1FFFF, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h0100, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  REG_NUM_COEFFS, 18'd3,     16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h0400, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'hFC00, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h7000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h9000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h0010, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  REG_NUM_COEFFS, 18'd5,     16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h0020, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h8001, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  REG_NUM_COEFFS, 18'd2,     16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  REG_COEF_0,     18'h08000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,  REG_COEF_1,     18'h00000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'h0001, 1'b1, 1'b1, 16'h0001, 1'b1},
      '{ROW_BEAT, 3'd0,           18'h00000, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 1'b1}
   };

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic [SAMPLE_W-1:0]        req_sample_in    = '0;
   logic                       req_end_of_array = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic [SAMPLE_W-1:0]        rsp_sample_out;
   logic                       rsp_last_out;
   logic                       csr_we           = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [COEF_WIDTH-1:0]      csr_wdata        = '0;

   // filter state as the core should hold it
   logic signed [SAMPLE_W-1:0]   window_q [WIN_LEN];
   logic [3:0]                   seen_q;
   logic [2:0]                   taps_q;
   logic signed [COEF_WIDTH-1:0] coef_q [MAX_TAPS];

   filt_result_type expected_q [$];
   int              beats_accepted = 0;
   int              mismatches     = 0;
   int              hold_left      = 0;
   bit              hold_done      = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   symmetric_fir_zero_edge_filter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_in    (req_sample_in),
      .req_end_of_array (req_end_of_array),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_last_out     (rsp_last_out),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   function automatic bit no_idle_stretch();
      return beats_accepted >= STEADY_FROM && beats_accepted < STEADY_TO;
   endfunction

   function automatic void clear_window();
      foreach (window_q[k]) window_q[k] = '0;
      seen_q = '0;
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_WIDTH-1:0] idx,
                                     logic [COEF_WIDTH-1:0] data);
      if (idx == REG_NUM_COEFFS) begin
         taps_q = data[2:0];
      end else begin
         coef_q[idx - REG_COEF_0] = data;
      end
   endfunction

   // filtered value centred p samples back from the newest
   function automatic logic [SAMPLE_W-1:0] filter_at(int p, int n);
      longint acc;
      longint lhs;
      longint rhs;
      longint r;
      if (n == 0) return window_q[p];
      acc = longint'(coef_q[0]) * longint'(window_q[p]);
      for (int j = 1; j < n; j++) begin
         rhs = (j <= p) ? longint'(window_q[p - j]) : 0;
         lhs = (p + j < WIN_LEN) ? longint'(window_q[p + j]) : 0;
         acc += longint'(coef_q[j]) * (lhs + rhs);
      end
      r = (acc + 64'sd32768) >>> 16;
      if (r > 32767) r = 32767;
      else if (r < -32768) r = -32768;
      return r[SAMPLE_W-1:0];
   endfunction

   function automatic void predict_beat(logic [SAMPLE_W-1:0] s, logic eoa);
      int n;
      int h;
      int count;
      n = (taps_q > MAX_TAPS) ? MAX_TAPS : int'(taps_q);
      h = (n == 0) ? 0 : n - 1;
      for (int k = WIN_LEN - 1; k > 0; k--) window_q[k] = window_q[k - 1];
      window_q[0] = s;
      if (seen_q < SEEN_MAX) seen_q++;
      if (!eoa) begin
         if (int'(seen_q) > h) expected_q.push_back('{filter_at(h, n), 1'b0});
      end else begin
         count = (int'(seen_q) < h + 1) ? int'(seen_q) : h + 1;
         for (int m = 0; m < count; m++)
            expected_q.push_back('{filter_at(count - 1 - m, n), m + 1 == count});
         clear_window();
      end
   endfunction

   task automatic send_beat(logic [SAMPLE_W-1:0] s, logic eoa);
      while (!no_idle_stretch() && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_in    <= s;
      req_end_of_array <= eoa;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_accepted++;
      predict_beat(s, eoa);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [COEF_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_csr(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (!hold_done && beats_accepted >= HOLD_AT) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle_stretch() || $urandom_range(0, 99) >= 10;
      end
   end

   always @(posedge clock) begin
      filt_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result beat, sample_out %0d last_out %0b", $time,
                     $signed(rsp_sample_out), rsp_last_out);
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_sample_out !== want.sample) begin
               $display("%0t: sample_out expected %0d got %0d", $time,
                        $signed(want.sample), $signed(rsp_sample_out));
               mismatches++;
            end
            if (rsp_last_out !== want.last_flag) begin
               $display("%0t: last_out expected %0b got %0b", $time,
                        want.last_flag, rsp_last_out);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("symmetric_fir_zero_edge_filter_core regression: fail");
      $finish;
   end

   initial begin
      stim_row_type          row;
      bit                    after_beat;
      bit                    open;
      int                    goal;
      int                    arrays;
      int                    len;
      int                    pick;
      logic [SAMPLE_W-1:0]   s;
      logic [COEF_WIDTH-1:0] c;

      clear_window();
      taps_q = NUM_COEFFS_RESET;
      foreach (coef_q[k]) coef_q[k] = '0;
      coef_q[0] = COEF0_RESET;
      after_beat = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         row = DIRECTED[i];
         if (row.kind == ROW_CSR) begin
            if (after_beat) wait_idle();
            after_beat = 1'b0;
            write_csr(row.index, row.data);
         end else begin
            send_beat(row.sample, row.eoa);
            after_beat = 1'b1;
            if (row.typed) expected_q[expected_q.size() - 1] = '{row.exp_sample, row.exp_last};
         end
      end

      goal = beats_accepted + RANDOM_BEATS;
      while (beats_accepted < goal) begin
         wait_idle();
         write_csr(REG_NUM_COEFFS, COEF_WIDTH'($urandom_range(0, 7)));
         for (int k = 0; k < MAX_TAPS; k++) begin
            pick = $urandom_range(0, 7);
            if (pick == 0) c = 18'h1FFFF;
            else if (pick == 1) c = 18'h20000;
            else if (pick == 2) c = 18'h10000;
            else if (pick == 7) c = COEF_WIDTH'($urandom);
            else c = COEF_WIDTH'($urandom_range(0, 32768)) - 18'd16384;
            write_csr(CSR_INDEX_WIDTH'(REG_COEF_0 + k), c);
         end
         arrays = $urandom_range(1, 4);
         for (int a = 0; a < arrays; a++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) len = $urandom_range(1, 10);
            else if (pick < 9) len = $urandom_range(11, 20);
            else len = $urandom_range(1, 2);
            // leave the last array open now and then so the next settings land mid-array
            open = (a == arrays - 1) && $urandom_range(0, 99) < 15;
            for (int k = 0; k < len; k++) begin
               pick = $urandom_range(0, 19);
               if (pick == 0) s = 16'h7FFF;
               else if (pick == 1) s = 16'h8000;
               else if (pick == 2) s = 16'h0000;
               else if (pick == 3) s = 16'hFFFF;
               else if (pick < 11) s = SAMPLE_W'($urandom_range(0, 4000)) - 16'd2000;
               else s = SAMPLE_W'($urandom);
               send_beat(s, (k == len - 1) && !open);
            end
         end
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("symmetric_fir_zero_edge_filter_core regression: pass");
      end else begin
         $display("symmetric_fir_zero_edge_filter_core regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/sfz_pkg.sv
rtl/sfz_front.sv
rtl/sfz_cmd_fifo.sv
rtl/sfz_back.sv
rtl/symmetric_fir_zero_edge_filter_core.sv
verif/tb_symmetric_fir_zero_edge_filter_core.sv
